@@ design/jse_pkg.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper package
// Word types, token kinds, character constants and small helpers shared by
// the front classifier, the job queue and the back emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package jse_pkg;

    // Input word: one raw byte of the string.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_of_string;
    } in_word_t;

    // Output word: one byte of escaped JSON text.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       end_of_string;
    } out_word_t;

    // How one classified byte is written out.
    typedef enum logic [1:0] {
        TOK_RAW   = 2'd0,  // byte as is
        TOK_SHORT = 2'd1,  // backslash and one character
        TOK_HEX   = 2'd2   // \u00xx of the byte
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] value;
    } tok_t;

    // Up to four tokens: three buffered bytes plus the new byte.
    localparam int unsigned JOB_TOKENS = 4;

    typedef struct packed {
        tok_t [JOB_TOKENS-1:0] tok;
        logic [2:0]            count;
        logic                  last;
    } job_t;

    // Job queue depth and derived widths.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Characters.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // Code point limits.
    localparam logic [20:0] CP_MIN2     = 21'h00080;
    localparam logic [20:0] CP_MIN3     = 21'h00800;
    localparam logic [20:0] CP_MIN4     = 21'h10000;
    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO  = 21'h0D800;
    localparam logic [20:0] CP_SURR_HI  = 21'h0DFFF;

    // Lower-case hex digit of a nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_LOW_A + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

    // Number of output bytes of a token.
    function automatic logic [2:0] tok_len(input tok_kind_t kind);
        logic [2:0] r;
        case (kind)
            TOK_RAW:   r = 3'd1;
            TOK_SHORT: r = 3'd2;
            TOK_HEX:   r = 3'd6;
            default:   r = 3'd1;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/jse_front.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper front end
// Accepts input words, tracks the pending UTF-8 sequence and turns each word
// that yields output into a job of up to four tokens for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             src_valid,
    output logic                  src_stall,
    input  wire jse_pkg::in_word_t src_word,
    input  wire logic             q_full,
    output logic                  push,
    output jse_pkg::job_t         job
);
    import jse_pkg::*;

    // Pending sequence state.
    logic [7:0]  pend_bytes_reg [0:2];
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    logic [2:0]  exp_len_reg, exp_len_next;
    logic [20:0] cp_reg, cp_next;

    logic        accept;
    logic [7:0]  c;
    logic        last;
    logic        is_cont;
    logic [2:0]  lead_len;
    logic [20:0] lead_cp;
    tok_kind_t   asc_kind;
    logic [7:0]  asc_val;
    logic [20:0] cp_new;
    logic [2:0]  cnt_p1;
    logic        complete;
    logic        seq_ok;

    logic [1:0]  pc;
    tok_kind_t   pend_kind;
    logic        c_emit;
    tok_kind_t   c_kind;
    logic [7:0]  c_val;
    logic        wr_en;
    logic [1:0]  wr_idx;

    assign c         = src_word.in_byte;
    assign last      = src_word.last_of_string;
    assign src_stall = q_full;
    assign accept    = src_valid && !q_full;
    assign is_cont   = (c[7:6] == 2'b10);

    // Lead byte decode.
    always_comb
    begin
        lead_len = 3'd0;
        lead_cp  = '0;
        if (c[7:5] == 3'b110) begin
            lead_len = 3'd2;
            lead_cp  = {16'd0, c[4:0]};
        end else if (c[7:4] == 4'b1110) begin
            lead_len = 3'd3;
            lead_cp  = {17'd0, c[3:0]};
        end else if (c[7:3] == 5'b11110) begin
            lead_len = 3'd4;
            lead_cp  = {18'd0, c[2:0]};
        end
    end

    // Single byte that does not open a sequence: ASCII rules or a lone byte.
    always_comb
    begin
        asc_kind = TOK_RAW;
        asc_val  = c;
        case (c)
            CH_QUOTE:  begin asc_kind = TOK_SHORT; asc_val = CH_QUOTE;  end
            CH_BSLASH: begin asc_kind = TOK_SHORT; asc_val = CH_BSLASH; end
            CH_LF:     begin asc_kind = TOK_SHORT; asc_val = CH_N;      end
            CH_CR:     begin asc_kind = TOK_SHORT; asc_val = CH_R;      end
            CH_TAB:    begin asc_kind = TOK_SHORT; asc_val = CH_T;      end
            CH_BS:     begin asc_kind = TOK_SHORT; asc_val = CH_B;      end
            CH_FF:     begin asc_kind = TOK_SHORT; asc_val = CH_F;      end
            default:
            begin
                if (c[7] || (c < CTRL_LIMIT)) begin
                    asc_kind = TOK_HEX;
                end
            end
        endcase
    end

    // Continuation arithmetic and the well-formedness check.
    assign cp_new   = {cp_reg[14:0], c[5:0]};
    assign cnt_p1   = {1'b0, pend_cnt_reg} + 3'd1;
    assign complete = (cnt_p1 >= exp_len_reg);

    always_comb
    begin
        seq_ok = 1'b1;
        if ((exp_len_reg == 3'd2) && (cp_new < CP_MIN2)) begin
            seq_ok = 1'b0;
        end else if ((exp_len_reg == 3'd3) && (cp_new < CP_MIN3)) begin
            seq_ok = 1'b0;
        end else if ((exp_len_reg == 3'd4) && (cp_new < CP_MIN4)) begin
            seq_ok = 1'b0;
        end
        if ((cp_new > CP_MAX) || ((cp_new >= CP_SURR_LO) && (cp_new <= CP_SURR_HI))) begin
            seq_ok = 1'b0;
        end
    end

    // Classification of the word and the next sequence state.
    always_comb
    begin
        pc            = 2'd0;
        pend_kind     = TOK_HEX;
        c_emit        = 1'b0;
        c_kind        = TOK_RAW;
        c_val         = c;
        wr_en         = 1'b0;
        wr_idx        = pend_cnt_reg;
        pend_cnt_next = pend_cnt_reg;
        exp_len_next  = exp_len_reg;
        cp_next       = cp_reg;
        if ((pend_cnt_reg != 2'd0) && is_cont) begin
            if (!complete) begin
                if (last) begin
                    // Incomplete tail: flush everything as escapes.
                    pc            = pend_cnt_reg;
                    c_emit        = 1'b1;
                    c_kind        = TOK_HEX;
                    pend_cnt_next = 2'd0;
                    exp_len_next  = 3'd0;
                    cp_next       = '0;
                end else begin
                    wr_en         = 1'b1;
                    pend_cnt_next = pend_cnt_reg + 2'd1;
                    cp_next       = cp_new;
                end
            end else begin
                // Sequence complete: pass through or escape every byte.
                pc            = pend_cnt_reg;
                pend_kind     = seq_ok ? TOK_RAW : TOK_HEX;
                c_emit        = 1'b1;
                c_kind        = seq_ok ? TOK_RAW : TOK_HEX;
                pend_cnt_next = 2'd0;
                exp_len_next  = 3'd0;
                cp_next       = '0;
            end
        end else begin
            // Broken sequence is flushed, then the byte starts afresh.
            pc            = pend_cnt_reg;
            pend_cnt_next = 2'd0;
            exp_len_next  = 3'd0;
            cp_next       = '0;
            if (lead_len != 3'd0) begin
                if (last) begin
                    c_emit = 1'b1;
                    c_kind = TOK_HEX;
                end else begin
                    wr_en         = 1'b1;
                    wr_idx        = 2'd0;
                    pend_cnt_next = 2'd1;
                    exp_len_next  = lead_len;
                    cp_next       = lead_cp;
                end
            end else begin
                c_emit = 1'b1;
                c_kind = asc_kind;
                c_val  = asc_val;
            end
        end
    end

    // Job assembly: buffered bytes first, then the new byte.
    always_comb
    begin
        job.tok = '0;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < pc) begin
                job.tok[i].kind  = pend_kind;
                job.tok[i].value = pend_bytes_reg[i];
            end
        end
        if (c_emit) begin
            job.tok[pc].kind  = c_kind;
            job.tok[pc].value = c_val;
        end
        job.count = {1'b0, pc} + {2'd0, c_emit};
        job.last  = last;
    end

    assign push = accept && (job.count != 3'd0);

    // Sequence state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_cnt_reg <= 2'd0;
            exp_len_reg  <= 3'd0;
            cp_reg       <= '0;
        end else if (accept) begin
            pend_cnt_reg <= pend_cnt_next;
            exp_len_reg  <= exp_len_next;
            cp_reg       <= cp_next;
        end
    end

    // Buffered bytes need no reset.
    always_ff @(posedge clk)
    begin
        if (accept && wr_en) begin
            pend_bytes_reg[wr_idx] <= c;
        end
    end

endmodule

`default_nettype wire

@@ design/jse_queue.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper job queue
// Short queue of jobs between the front and back ends, so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire jse_pkg::job_t push_job,
    output logic               full,
    output logic               head_valid,
    output jse_pkg::job_t      head_job,
    input  wire logic          pop
);
    import jse_pkg::*;

    job_t                 q_mem_reg [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_job   = q_mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + Q_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + Q_PTR_W'(1);
            end
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

@@ design/jse_back.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper back end
// Walks the tokens of the head job and emits one output word per cycle, while
// dst does not stall, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jse_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire jse_pkg::job_t  head_job,
    output logic                pop,
    output logic                dst_valid,
    input  wire logic           dst_stall,
    output jse_pkg::out_word_t  dst_word
);
    import jse_pkg::*;

    logic [1:0]  tok_idx_reg;
    logic [2:0]  sub_reg;
    logic        out_valid_reg;
    out_word_t   out_word_reg;

    tok_t        cur;
    logic        last_sub;
    logic        last_tok;
    logic        advance;
    logic [7:0]  byte_sel;

    assign cur      = head_job.tok[tok_idx_reg];
    assign last_sub = (sub_reg == (tok_len(cur.kind) - 3'd1));
    assign last_tok = (({1'b0, tok_idx_reg} + 3'd1) == head_job.count);
    assign advance  = head_valid && (!out_valid_reg || !dst_stall);
    assign pop      = advance && last_sub && last_tok;

    // Byte of the current token at the current position.
    always_comb
    begin
        byte_sel = cur.value;
        case (cur.kind)
            TOK_RAW:   byte_sel = cur.value;
            TOK_SHORT: byte_sel = (sub_reg == 3'd0) ? CH_BSLASH : cur.value;
            TOK_HEX:
            begin
                case (sub_reg)
                    3'd0:    byte_sel = CH_BSLASH;
                    3'd1:    byte_sel = CH_U;
                    3'd2:    byte_sel = CH_ZERO;
                    3'd3:    byte_sel = CH_ZERO;
                    3'd4:    byte_sel = hex_char(cur.value[7:4]);
                    default: byte_sel = hex_char(cur.value[3:0]);
                endcase
            end
            default:   byte_sel = cur.value;
        endcase
    end

    // Token walk and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tok_idx_reg   <= 2'd0;
            sub_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                out_valid_reg <= 1'b1;
                if (last_sub) begin
                    sub_reg     <= 3'd0;
                    tok_idx_reg <= last_tok ? 2'd0 : tok_idx_reg + 2'd1;
                end else begin
                    sub_reg <= sub_reg + 3'd1;
                end
            end else if (!dst_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_word_reg.out_byte      <= byte_sel;
            out_word_reg.last_of_run   <= last_sub && last_tok;
            out_word_reg.end_of_string <= last_sub && last_tok && head_job.last;
        end
    end

    assign dst_valid = out_valid_reg;
    assign dst_word  = out_word_reg;

endmodule

`default_nettype wire

@@ design/json_string_escaper_utf8_core.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper with UTF-8 validation
// Escapes a byte stream into JSON string text, checking UTF-8 sequences.
//
// The src channel takes one string byte per word, with a flag on the last
// byte of the string. The dst channel gives one byte of escaped text per
// word, flagged on the last byte caused by each input word and on the final
// byte of the string. Both channels use valid and stall.
// A front end classifies each word against the pending UTF-8 sequence and
// queues a job of up to four tokens; a back end writes one output byte per
// cycle from the head job while dst does not stall. An input word gives as
// many output bytes as its tokens need: one for a plain byte, two for a short
// escape, six for a \u00xx escape, up to 24 for a flushed sequence; plain
// text flows at one byte per cycle while dst does not stall. The first output
// byte of a word is held in the job queue, then in the output register.
// A word that only extends a pending sequence yields nothing until the sequence ends.
// Reset clears the pending sequence, the job queue and the output valid flag.
// When dst stalls, the output register holds, the queue fills and src stalls
// once its two entries are taken.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_escaper_utf8_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire jse_pkg::in_word_t  src_word,
    output logic                    dst_valid,
    input  wire logic               dst_stall,
    output jse_pkg::out_word_t      dst_word
);
    import jse_pkg::*;

    logic  push;
    job_t  push_job;
    logic  q_full;
    logic  head_valid;
    job_t  head_job;
    logic  pop;

    // Classifier and sequence tracker.
    jse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .q_full    (q_full),
        .push      (push),
        .job       (push_job)
    );

    // Job queue between the two halves.
    jse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    // Byte emitter.
    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .dst_valid  (dst_valid),
        .dst_stall  (dst_stall),
        .dst_word   (dst_word)
    );

endmodule

`default_nettype wire

@@ tb/json_string_escaper_utf8_core_tb.sv @@
// ----------------------------------------------------------------------------
// JSON string escaper with UTF-8 validation: testbench
// Drives byte strings into the escaper and checks every escaped output word
// against a predictor of the JSON escaping and UTF-8 validation rules. A
// short directed string set covers the short escapes, control bytes, lone
// bytes, overlong forms, surrogates, code points out of range, broken
// sequences and an incomplete tail. Random strings follow, mostly well-formed
// UTF-8 text with some noise. Both sides idle at random, and at one point the
// receiver holds off long enough to back the block up into its input.
// ----------------------------------------------------------------------------

module json_string_escaper_utf8_core_tb;

    import jse_pkg::*;

    // Characters written by the escaper.
    localparam logic [7:0] ASC_QUOTE  = 8'h22;
    localparam logic [7:0] ASC_BSLASH = 8'h5C;
    localparam logic [7:0] ASC_LF     = 8'h0A;
    localparam logic [7:0] ASC_CR     = 8'h0D;
    localparam logic [7:0] ASC_TAB    = 8'h09;
    localparam logic [7:0] ASC_BS     = 8'h08;
    localparam logic [7:0] ASC_FF     = 8'h0C;
    localparam logic [7:0] ASC_SPACE  = 8'h20;
    localparam logic [7:0] ASC_N      = 8'h6E;
    localparam logic [7:0] ASC_R      = 8'h72;
    localparam logic [7:0] ASC_T      = 8'h74;
    localparam logic [7:0] ASC_B      = 8'h62;
    localparam logic [7:0] ASC_F      = 8'h66;
    localparam logic [7:0] ASC_U      = 8'h75;
    localparam logic [7:0] ASC_ZERO   = 8'h30;
    localparam logic [7:0] NO_ESCAPE  = 8'h00;

    // Directed strings, first byte in the top bits. A set bit in the end
    // mask marks the final byte of a string.
    localparam int unsigned DIRECTED_COUNT = 25;
    localparam logic [8*DIRECTED_COUNT-1:0] DIRECTED_TEXT = {
        8'h00, 8'h22, 8'h5C, 8'h0A, 8'h0D, 8'h09, 8'h08, 8'h0C, 8'hFF,
        8'h80, 8'hC3, 8'hA9, 8'hC0, 8'h80, 8'hE2, 8'h41,
        8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
        8'hE2, 8'h82
    };
    localparam logic [DIRECTED_COUNT-1:0] DIRECTED_ENDS = 25'h1408100;

    localparam int unsigned RANDOM_ITEMS   = 195;
    localparam int unsigned HOLD_CYCLES    = 100;
    localparam int unsigned SETTLE_CYCLES  = 30;
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    // Predictor of the escaped text and store of the words still to come.
    class escaped_text_board;
        logic [7:0]  held [3];
        int unsigned held_n;
        int unsigned seq_len;
        logic [20:0] code_pt;
        logic [7:0]  run_text [$];
        out_word_t   expected_text [$];
        int unsigned errors;

        function new();
            held_n  = 0;
            seq_len = 0;
            code_pt = '0;
            errors  = 0;
        endfunction

        function int unsigned outstanding();
            return expected_text.size();
        endfunction

        // Append one byte to the text of the current run.
        function void add_text(logic [7:0] b);
            run_text.insert(run_text.size(), b);
        endfunction

        // Six-byte \u00xx form of one byte, lower-case hex.
        function void emit_hex(logic [7:0] c);
            string hex_digits;
            hex_digits = "0123456789abcdef";
            add_text(ASC_BSLASH);
            add_text(ASC_U);
            add_text(ASC_ZERO);
            add_text(ASC_ZERO);
            add_text(hex_digits[c[7:4]]);
            add_text(hex_digits[c[3:0]]);
        endfunction

        // A byte below 0x80: short escape, hex escape or the byte itself.
        function void emit_plain(logic [7:0] c);
            logic [7:0] esc;
            case (c)
                ASC_QUOTE:  esc = ASC_QUOTE;
                ASC_BSLASH: esc = ASC_BSLASH;
                ASC_LF:     esc = ASC_N;
                ASC_CR:     esc = ASC_R;
                ASC_TAB:    esc = ASC_T;
                ASC_BS:     esc = ASC_B;
                ASC_FF:     esc = ASC_F;
                default:    esc = NO_ESCAPE;
            endcase
            if (esc != NO_ESCAPE)
            begin
                add_text(ASC_BSLASH);
                add_text(esc);
            end
            else if (c < ASC_SPACE)
            begin
                emit_hex(c);
            end
            else
            begin
                add_text(c);
            end
        endfunction

        // Every held byte of an unfinished sequence goes out as a hex escape.
        function void drop_held();
            for (int unsigned k = 0; k < held_n; k++)
            begin
                emit_hex(held[k]);
            end
            held_n  = 0;
            seq_len = 0;
            code_pt = '0;
        endfunction

        // A byte seen with no sequence pending.
        function void open_seq(logic [7:0] c);
            if (c < 8'h80)
            begin
                emit_plain(c);
                return;
            end
            if (c[7:5] == 3'b110)
            begin
                seq_len = 2;
                code_pt = {16'd0, c[4:0]};
            end
            else if (c[7:4] == 4'b1110)
            begin
                seq_len = 3;
                code_pt = {17'd0, c[3:0]};
            end
            else if (c[7:3] == 5'b11110)
            begin
                seq_len = 4;
                code_pt = {18'd0, c[2:0]};
            end
            else
            begin
                emit_hex(c);
                return;
            end
            held[0] = c;
            held_n  = 1;
        endfunction

        // A continuation byte while a sequence is pending.
        function void extend_seq(logic [7:0] c);
            logic [20:0] cp;
            bit          good;
            cp = {code_pt[14:0], c[5:0]};
            if (held_n + 1 < seq_len)
            begin
                held[held_n] = c;
                held_n++;
                code_pt = cp;
                return;
            end
            // Complete: reject overlong forms, surrogates and values past the top.
            good = 1'b1;
            if (seq_len == 2 && cp < 21'h00080)
                good = 1'b0;
            else if (seq_len == 3 && cp < 21'h00800)
                good = 1'b0;
            else if (seq_len == 4 && cp < 21'h10000)
                good = 1'b0;
            if (cp > 21'h10FFFF || (cp >= 21'h0D800 && cp <= 21'h0DFFF))
                good = 1'b0;
            if (good)
            begin
                for (int unsigned k = 0; k < held_n; k++)
                begin
                    add_text(held[k]);
                end
                add_text(c);
                held_n  = 0;
                seq_len = 0;
                code_pt = '0;
            end
            else
            begin
                drop_held();
                emit_hex(c);
            end
        endfunction

        // Note an accepted input word and queue the output words it causes.
        function void take_byte(in_word_t w);
            out_word_t o;
            run_text.delete();
            if (held_n != 0)
            begin
                if (w.in_byte[7:6] == 2'b10)
                begin
                    extend_seq(w.in_byte);
                end
                else
                begin
                    drop_held();
                    open_seq(w.in_byte);
                end
            end
            else
            begin
                open_seq(w.in_byte);
            end
            if (w.last_of_string)
                drop_held();
            foreach (run_text[k])
            begin
                o.out_byte      = run_text[k];
                o.last_of_run   = (k == run_text.size() - 1);
                o.end_of_string = o.last_of_run && w.last_of_string;
                expected_text.insert(expected_text.size(), o);
            end
        endfunction

        // Check an accepted output word against the oldest expectation.
        function void match_out_byte(out_word_t got);
            out_word_t want;
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected word: byte %02h run %0b end %0b",
                         $time, got.out_byte, got.last_of_run, got.end_of_string);
                errors++;
                return;
            end
            want = expected_text.pop_front();
            if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run ||
                got.end_of_string !== want.end_of_string)
            begin
                $display("%0t: mismatch: expected %02h/%0b/%0b, actual %02h/%0b/%0b",
                         $time, want.out_byte, want.last_of_run, want.end_of_string,
                         got.out_byte, got.last_of_run, got.end_of_string);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n = 1'b0;
    logic      src_valid;
    logic      src_stall;
    in_word_t  src_word;
    logic      dst_valid;
    logic      dst_stall;
    out_word_t dst_word;

    escaped_text_board board;
    logic [7:0] str_bytes [$];
    bit         tx_idle_on;
    bit         rx_idle_on;
    bit         hold_req;

    json_string_escaper_utf8_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle length: mostly none, sometimes short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    // Append one byte to the string being built.
    function automatic void append_byte(logic [7:0] b);
        str_bytes.insert(str_bytes.size(), b);
    endfunction

    // Append the UTF-8 form of a code point in n bytes; a longer n than
    // needed gives an overlong form.
    function automatic void push_utf8(logic [20:0] cp, int unsigned n);
        case (n)
            2:
            begin
                append_byte({3'b110, cp[10:6]});
                append_byte({2'b10, cp[5:0]});
            end
            3:
            begin
                append_byte({4'b1110, cp[15:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            4:
            begin
                append_byte({5'b11110, cp[20:18]});
                append_byte({2'b10, cp[17:12]});
                append_byte({2'b10, cp[11:6]});
                append_byte({2'b10, cp[5:0]});
            end
            default:
            begin
                append_byte({1'b0, cp[6:0]});
            end
        endcase
    endfunction

    // One random piece of text: mostly well-formed characters, some noise.
    function automatic void add_piece();
        int unsigned pick;
        int unsigned n;
        int unsigned cut;
        logic [20:0] cp;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            append_byte(8'($urandom_range(0, 8'h7F)));
        end
        else if (pick < 45)
        begin
            push_utf8(21'($urandom_range(21'h80, 21'h7FF)), 2);
        end
        else if (pick < 58)
        begin
            if ($urandom_range(0, 1) != 0)
                cp = 21'($urandom_range(21'h800, 21'hD7FF));
            else
                cp = 21'($urandom_range(21'hE000, 21'hFFFF));
            push_utf8(cp, 3);
        end
        else if (pick < 68)
        begin
            push_utf8(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
        end
        else if (pick < 75)
        begin
            // Lone byte: stray continuation or invalid lead.
            if ($urandom_range(0, 1) != 0)
                append_byte(8'($urandom_range(8'h80, 8'hBF)));
            else
                append_byte(8'($urandom_range(8'hF8, 8'hFF)));
        end
        else if (pick < 82)
        begin
            n = $urandom_range(2, 4);
            if (n == 2)
                cp = 21'($urandom_range(0, 21'h7F));
            else if (n == 3)
                cp = 21'($urandom_range(0, 21'h7FF));
            else
                cp = 21'($urandom_range(0, 21'hFFFF));
            push_utf8(cp, n);
        end
        else if (pick < 87)
        begin
            push_utf8(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
        end
        else if (pick < 91)
        begin
            push_utf8(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        end
        else if (pick < 96)
        begin
            // Broken sequence: a well-formed four-byte character cut short, or cut away whole.
            n = $urandom_range(2, 4);
            push_utf8(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
            if (n < 4)
            begin
                str_bytes.delete(str_bytes.size() - 1);
            end
            cut = $urandom_range(1, 3);
            while (cut > 0)
            begin
                str_bytes.delete(str_bytes.size() - 1);
                cut--;
            end
        end
        else
        begin
            append_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    // Offer one input word and wait until it is taken.
    task automatic send_word(input logic [7:0] b, input logic last);
        in_word_t    w;
        int unsigned gap;
        w.in_byte        = b;
        w.last_of_string = last;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word  <= w;
        do
            @(posedge clk);
        while (src_stall);
        board.take_byte(w);
    endtask

    // Send the current string, flagging its final byte.
    task automatic send_string();
        foreach (str_bytes[k])
        begin
            send_word(str_bytes[k], k == str_bytes.size() - 1);
        end
    endtask

    // Sender side and overall sequence.
    initial
    begin : feed_side
        int unsigned fed;
        int unsigned pieces;
        bit          hold_done;
        board      = new();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        hold_req   = 1'b0;
        hold_done  = 1'b0;
        src_valid <= 1'b0;
        src_word  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings.
        for (int unsigned k = 0; k < DIRECTED_COUNT; k++)
        begin
            send_word(DIRECTED_TEXT[8*(DIRECTED_COUNT-1-k) +: 8], DIRECTED_ENDS[k]);
        end

        // Random strings, with idling switched per string.
        fed = 0;
        while (fed < RANDOM_ITEMS)
        begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (!hold_done && fed >= RANDOM_ITEMS / 2)
            begin
                // Long receiver hold-off while the sender keeps offering.
                hold_req   = 1'b1;
                hold_done  = 1'b1;
                tx_idle_on = 1'b0;
            end
            str_bytes.delete();
            pieces = $urandom_range(1, 6);
            while (str_bytes.size() == 0 || pieces > 0)
            begin
                add_piece();
                if (pieces > 0)
                    pieces--;
            end
            send_string();
            fed += str_bytes.size();
        end
        src_valid <= 1'b0;

        // Drain, then allow for any stray words.
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver side: random stalls, one long hold-off on request.
    initial
    begin : drain_side
        int unsigned stall_left;
        stall_left = 0;
        dst_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (dst_valid && !dst_stall)
                board.match_out_byte(dst_word);
            if (stall_left == 0)
            begin
                if (hold_req)
                begin
                    stall_left = HOLD_CYCLES;
                    hold_req   = 1'b0;
                end
                else if (rx_idle_on)
                begin
                    stall_left = pick_gap();
                end
            end
            if (stall_left > 0)
            begin
                dst_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                dst_stall <= 1'b0;
            end
        end
    end

    // Watchdog: too many cycles with no word moving on either side.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((src_valid && !src_stall) || (dst_valid && !dst_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule
